>>> rtl/core/rfa_pkg.sv
`timescale 1ns / 1ps

package rfa_pkg;

    localparam int NUM_WORKERS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 16;

    localparam logic [1:0] REQ_GET      = 2'd0;
    localparam logic [1:0] REQ_GIVE     = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;

    localparam logic [1:0] HAND_LEFT  = 2'd0;
    localparam logic [1:0] HAND_RIGHT = 2'd1;

    localparam logic [1:0] MSG_GRANT = 2'd0;
    localparam logic [1:0] MSG_ACK   = 2'd1;
    localparam logic [1:0] MSG_KIT   = 2'd2;

    typedef enum logic [2:0] {
        HS_IDLE  = 3'd0,
        HS_EMPTY = 3'd1,
        HS_LEFT  = 3'd2,
        HS_RIGHT = 3'd3,
        HS_WAITR = 3'd4
    } hand_status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] hand;
        logic [3:0] worker;
    } req_t;

    typedef struct packed {
        logic [1:0] msg_kind;
        logic [3:0] target_worker;
        logic       granted_hand;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic ack;
        logic kit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       worker_ok;
        logic       scan_done;
        logic       out_free;
    } stat_t;

endpackage

>>> rtl/core/ring_fork_arbiter.sv
`timescale 1ns / 1ps

// Channel   Signals                          Direction  Carries
// request   req_valid, req_ready, req_data   in         req_type, hand, worker
// response  rsp_valid, rsp_ready, rsp_data   out        msg_kind, target_worker, granted_hand, last
//
// One request is handled at a time. A get or an ignored request ends in the execute state,
// a part completion adds a kit step, and a give adds a rescan and an ack step; the rescan
// visits one wait queue entry a cycle while the response register is free. Each result waits
// while the response register is held by a stalled earlier result. Reset clears forks, hand
// states, queue length and part counts at once; no clearing pass is needed.
module ring_fork_arbiter
#(
    parameter int NUM_WORKERS = rfa_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = rfa_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rfa_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rfa_pkg::rsp_t rsp_data
);

    rfa_pkg::cmd_t  cmd;
    rfa_pkg::stat_t stat;

    rfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rfa_datapath
    #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

>>> rtl/core/rfa_ctrl.sv
`timescale 1ns / 1ps

module rfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rfa_pkg::stat_t stat,
    output rfa_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_ACK  = 5'b01000,
        S_KIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.worker_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.exec = 1'b1;
                    case (stat.req_type)
                        rfa_pkg::REQ_GIVE:     state_next = S_SCAN;
                        rfa_pkg::REQ_COMPLETE: state_next = S_KIT;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_ACK;
                end
                else if (stat.out_free)
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.ack    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_KIT:
            begin
                if (stat.out_free)
                begin
                    cmd.kit    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/rfa_datapath.sv
`timescale 1ns / 1ps

module rfa_datapath
#(
    parameter int NUM_WORKERS = rfa_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = rfa_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  rfa_pkg::req_t  req_data,
    input  rfa_pkg::cmd_t  cmd,
    output rfa_pkg::stat_t stat,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rfa_pkg::rsp_t  rsp_data
);

    localparam int IW = $clog2(NUM_WORKERS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = rfa_pkg::COUNT_W;

    rfa_pkg::req_t        req_reg;
    logic [NUM_WORKERS-1:0] busy_reg;
    rfa_pkg::hand_status_t status_reg [NUM_WORKERS];
    logic [3:0]           queue_reg [QUEUE_DEPTH];
    logic [3:0]           queue_next [QUEUE_DEPTH];
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        len_next;
    logic [3:0]           snap_reg [QUEUE_DEPTH];
    logic [LW-1:0]        snap_len_reg;
    logic [LW-1:0]        k_reg;
    logic [CW-1:0]        count_reg [NUM_WORKERS];
    logic                 rsp_valid_reg;
    rfa_pkg::rsp_t        rsp_reg;

    logic [IW-1:0] w;
    logic [IW-1:0] m;
    logic [IW-1:0] cur;
    logic [IW-1:0] cur_left;
    logic [IW-1:0] cur_right;
    logic          pn_found;
    logic          pm_found;
    logic [QW-1:0] pn;
    logic [QW-1:0] pm;
    logic          scan_left;
    logic          scan_right;
    logic          do_append;
    logic          do_remove;
    logic          all_full;
    logic          emit;
    rfa_pkg::rsp_t emit_data;

    assign w   = req_reg.worker[IW-1:0];
    assign m   = snap_reg[k_reg[QW-1:0]][IW-1:0];
    assign cur = cmd.scan ? m : w;
    assign cur_left  = (cur == '0) ? IW'(NUM_WORKERS - 1) : cur - IW'(1);
    assign cur_right = (cur == IW'(NUM_WORKERS - 1)) ? '0 : cur + IW'(1);

    always_comb
    begin
        pn_found = 1'b0;
        pm_found = 1'b0;
        pn       = '0;
        pm       = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (LW'(i) < len_reg && queue_reg[i] == 4'(cur_left))
            begin
                pn_found = 1'b1;
                pn       = QW'(i);
            end
            if (LW'(i) < len_reg && queue_reg[i] == 4'(cur))
            begin
                pm_found = 1'b1;
                pm       = QW'(i);
            end
        end
    end

    assign scan_left = (status_reg[m] == rfa_pkg::HS_EMPTY) && !busy_reg[m]
                       && (!pn_found || !pm_found || pn > pm);
    assign scan_right = !scan_left && (status_reg[m] == rfa_pkg::HS_WAITR)
                        && !busy_reg[cur_right];

    always_comb
    begin
        all_full = 1'b1;
        for (int i = 0; i < NUM_WORKERS; i++)
        begin
            if (count_reg[i] == '0)
            begin
                all_full = 1'b0;
            end
        end
    end

    always_comb
    begin
        do_append = 1'b0;
        do_remove = 1'b0;
        if (cmd.exec && req_reg.req_type == rfa_pkg::REQ_GET)
        begin
            if (req_reg.hand == rfa_pkg::HAND_LEFT)
            begin
                do_append = (len_reg < LW'(QUEUE_DEPTH));
            end
            else if (req_reg.hand == rfa_pkg::HAND_RIGHT)
            begin
                do_remove = !busy_reg[cur_right] && pm_found;
            end
        end
        if (cmd.scan && scan_right)
        begin
            do_remove = pm_found;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queue_next[i] = queue_reg[i];
        end
        if (do_append)
        begin
            queue_next[len_reg[QW-1:0]] = 4'(w);
            len_next = len_reg + LW'(1);
        end
        if (do_remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (QW'(i) >= pm)
                begin
                    queue_next[i] = queue_reg[i + 1];
                end
            end
            len_next = len_reg - LW'(1);
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_data = '0;
        if (cmd.exec && req_reg.req_type == rfa_pkg::REQ_GET)
        begin
            if (req_reg.hand == rfa_pkg::HAND_LEFT && !pn_found && !busy_reg[w])
            begin
                emit = 1'b1;
                emit_data = '{rfa_pkg::MSG_GRANT, req_reg.worker, 1'b0, 1'b1};
            end
            else if (req_reg.hand == rfa_pkg::HAND_RIGHT && !busy_reg[cur_right])
            begin
                emit = 1'b1;
                emit_data = '{rfa_pkg::MSG_GRANT, req_reg.worker, 1'b1, 1'b1};
            end
        end
        if (cmd.scan && (scan_left || scan_right))
        begin
            emit = 1'b1;
            emit_data = '{rfa_pkg::MSG_GRANT, 4'(m), scan_right, 1'b0};
        end
        if (cmd.ack)
        begin
            emit = 1'b1;
            emit_data = '{rfa_pkg::MSG_ACK, req_reg.worker, 1'b0, 1'b1};
        end
        if (cmd.kit && all_full)
        begin
            emit = 1'b1;
            emit_data = '{rfa_pkg::MSG_KIT, 4'd0, 1'b0, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                snap_reg[i] <= queue_reg[i];
            end
        end
        if (emit)
        begin
            rsp_reg <= emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            len_reg       <= '0;
            snap_len_reg  <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                status_reg[i] <= rfa_pkg::HS_IDLE;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            len_reg <= len_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                snap_len_reg <= len_reg;
                k_reg        <= '0;
                case (req_reg.req_type)
                    rfa_pkg::REQ_GET:
                    begin
                        if (req_reg.hand == rfa_pkg::HAND_LEFT)
                        begin
                            if (!pn_found && !busy_reg[w])
                            begin
                                busy_reg[w]   <= 1'b1;
                                status_reg[w] <= rfa_pkg::HS_LEFT;
                            end
                            else
                            begin
                                status_reg[w] <= rfa_pkg::HS_EMPTY;
                            end
                        end
                        else if (req_reg.hand == rfa_pkg::HAND_RIGHT)
                        begin
                            if (!busy_reg[cur_right])
                            begin
                                busy_reg[cur_right] <= 1'b1;
                                status_reg[w]       <= rfa_pkg::HS_RIGHT;
                            end
                            else
                            begin
                                status_reg[w] <= rfa_pkg::HS_WAITR;
                            end
                        end
                    end
                    rfa_pkg::REQ_GIVE:
                    begin
                        if (req_reg.hand == rfa_pkg::HAND_LEFT)
                        begin
                            busy_reg[w]   <= 1'b0;
                            status_reg[w] <= rfa_pkg::HS_EMPTY;
                        end
                        else if (req_reg.hand == rfa_pkg::HAND_RIGHT)
                        begin
                            busy_reg[cur_right] <= 1'b0;
                            status_reg[w]       <= rfa_pkg::HS_LEFT;
                        end
                    end
                    rfa_pkg::REQ_COMPLETE:
                    begin
                        if (count_reg[w] != '1)
                        begin
                            count_reg[w] <= count_reg[w] + CW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan)
            begin
                k_reg <= k_reg + LW'(1);
                if (scan_left)
                begin
                    busy_reg[m]   <= 1'b1;
                    status_reg[m] <= rfa_pkg::HS_LEFT;
                end
                else if (scan_right)
                begin
                    busy_reg[cur_right] <= 1'b1;
                    status_reg[m]       <= rfa_pkg::HS_RIGHT;
                end
            end
            if (cmd.kit && all_full)
            begin
                for (int i = 0; i < NUM_WORKERS; i++)
                begin
                    count_reg[i] <= count_reg[i] - CW'(1);
                end
            end
        end
    end

    assign stat.req_type  = req_reg.req_type;
    assign stat.worker_ok = ({1'b0, req_reg.worker} < 5'(NUM_WORKERS));
    assign stat.scan_done = (k_reg == snap_len_reg);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

>>> rtl/core/rfa_checker.sv
`timescale 1ns / 1ps

module rfa_checker
#(
    parameter int NUM_WORKERS = rfa_pkg::NUM_WORKERS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input rfa_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input rfa_pkg::rsp_t rsp_data
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
        else $error("Request changed while waiting.");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("Response changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request taken while another is in progress.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.msg_kind != 2'd3)
        else $error("Illegal message kind.");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> {1'b0, rsp_data.target_worker} < 5'(NUM_WORKERS))
        else $error("Target worker out of range.");

endmodule

bind ring_fork_arbiter rfa_checker #(.NUM_WORKERS(NUM_WORKERS)) u_rfa_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
